FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent checks, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, c, r, ante, cons, msg) \
    label: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, c, r, ante, cons, msg) \
    label: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lkc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lkc_pkg
// Shared widths, constants and types for the LRU key cache policy.
// ---------------------------------------------------------------------------
package lkc_pkg;

    localparam int KEY_W = 32;
    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Flags from the shared entry unit
    typedef struct packed {
        logic key_eq;
        logic age_gt;
        logic age_lt;
    } cmp_res_t;

endpackage

FILE: rtl/lkc_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lkc_if
// Valid/ready channel interfaces for access and result transactions.
// ---------------------------------------------------------------------------
interface lkc_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [lkc_pkg::KEY_W-1:0] access_key;

    modport source (output valid, output access_key, input ready);
    modport sink   (input valid, input access_key, output ready);
endinterface

interface lkc_out_if;
    logic                             valid;
    logic                             ready;
    logic                             hit;
    logic                             evict_valid;
    logic signed [lkc_pkg::KEY_W-1:0] evicted_key;

    modport source (output valid, output hit, output evict_valid, output evicted_key,
                    input ready);
    modport sink   (input valid, input hit, input evict_valid, input evicted_key,
                    output ready);
endinterface

FILE: rtl/lkc_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lkc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module lkc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/lkc_alu.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lkc_alu
// Shared entry unit: key match, age compare and age increment.
// ---------------------------------------------------------------------------
module lkc_alu #(
    parameter int AGE_W = 4
) (
    input  logic [lkc_pkg::KEY_W-1:0] ent_key,
    input  logic [AGE_W-1:0]          ent_age,
    input  logic [lkc_pkg::KEY_W-1:0] acc_key,
    input  logic [AGE_W-1:0]          ref_age,
    output lkc_pkg::cmp_res_t         res,
    output logic [AGE_W-1:0]          age_inc
);

    import lkc_pkg::*;

    always_comb
    begin
        res.key_eq = (ent_key == acc_key);
        res.age_gt = (ent_age > ref_age);
        res.age_lt = (ent_age < ref_age);
        age_inc    = ent_age + AGE_W'(1);
    end

endmodule

FILE: rtl/lru_key_cache_policy.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lru_key_cache_policy
// Least-recently-used key set with hit and eviction reporting.
// ---------------------------------------------------------------------------
// Each access transaction carries one 32-bit key and yields exactly one
// result transaction: hit, evict_valid and evicted_key (zero unless a key was
// evicted). Up to min(max(capacity, 2), ENTRIES) keys are held; a hit makes
// the key the most recent, a miss inserts it, evicting the least recent key
// once the set is full. Keys and ages live in one ENTRIES-deep RAM; valid bits
// and the occupancy count are flops cleared at reset, so no clearing pass is
// needed. Each access makes two sweeps over the RAM's single read port: a
// search sweep and an age update sweep. One access is in flight at a time;
// the result register lets the next access be taken while the previous
// result waits. The user must see that capacity is written through
// cfg_we/cfg_wdata only while idle; the block itself does not enforce this.
module lru_key_cache_policy #(
    parameter int ENTRIES = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [lkc_pkg::CAP_W-1:0] cfg_wdata,
    lkc_in_if.sink                    in_ch,
    lkc_out_if.source                 out_ch
);

    import lkc_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int AGE_W  = IDX_W;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int WORD_W = KEY_W + AGE_W;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    // What the access does to the set
    typedef enum logic [1:0] {
        KIND_HIT,
        KIND_INSERT,
        KIND_EVICT
    } kind_t;

    state_t             state_reg, state_next;
    kind_t              kind_reg, kind_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;       // read address sweep
    logic               chk_reg, chk_next;       // RAM data valid this cycle
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]   occ_reg, occ_next;
    logic [CAP_W-1:0]   cap_reg, cap_next;

    logic               found_reg, found_next;
    logic [IDX_W-1:0]   found_idx_reg, found_idx_next;
    logic [AGE_W-1:0]   found_age_reg, found_age_next;
    logic               free_reg, free_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic               old_reg, old_next;
    logic [IDX_W-1:0]   old_idx_reg, old_idx_next;
    logic [AGE_W-1:0]   old_age_reg, old_age_next;
    logic [KEY_W-1:0]   old_key_reg, old_key_next;
    logic [IDX_W-1:0]   tgt_idx_reg, tgt_idx_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_hit_reg, out_hit_next;
    logic               out_evv_reg, out_evv_next;
    logic [KEY_W-1:0]   out_evk_reg, out_evk_next;

    // RAM and shared unit
    logic               ram_we, ram_re;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    logic [WORD_W-1:0]  ram_wdata, ram_rdata;
    logic [KEY_W-1:0]   rd_key;
    logic [AGE_W-1:0]   rd_age;
    logic [AGE_W-1:0]   ref_age;
    logic [AGE_W-1:0]   age_inc;
    cmp_res_t           res;

    logic               ent_valid;
    logic               sweep_end;
    logic [CMP_W-1:0]   cap_ext, eff_cap;

    lkc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key = ram_rdata[WORD_W-1:AGE_W];
    assign rd_age = ram_rdata[AGE_W-1:0];

    // Search compares against the running oldest; update against the hit's age
    assign ref_age = (state_reg == ST_SCAN) ? old_age_reg : found_age_reg;

    lkc_alu #(
        .AGE_W (AGE_W)
    ) u_alu (
        .ent_key (rd_key),
        .ent_age (rd_age),
        .acc_key (key_reg),
        .ref_age (ref_age),
        .res     (res),
        .age_inc (age_inc)
    );

    assign ent_valid = valid_reg[chk_idx_reg];
    // All reads issued and the last one checked
    assign sweep_end = (cnt_reg == CNT_W'(ENTRIES)) && !chk_reg;

    // Effective capacity, saturated to [2, ENTRIES]
    assign cap_ext = CMP_W'(cap_reg);
    always_comb
    begin
        if (cap_ext < CMP_W'(2))
        begin
            eff_cap = CMP_W'(2);
        end
        else if (cap_ext > CMP_W'(ENTRIES))
        begin
            eff_cap = CMP_W'(ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign in_ch.ready        = (state_reg == ST_IDLE);
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.hit         = out_hit_reg;
    assign out_ch.evict_valid = out_evv_reg;
    assign out_ch.evicted_key = out_evk_reg;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        cnt_next       = cnt_reg;
        chk_next       = chk_reg;
        chk_idx_next   = chk_idx_reg;
        key_next       = key_reg;
        valid_next     = valid_reg;
        occ_next       = occ_reg;
        cap_next       = cap_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        found_age_next = found_age_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        old_next       = old_reg;
        old_idx_next   = old_idx_reg;
        old_age_next   = old_age_reg;
        old_key_next   = old_key_reg;
        tgt_idx_next   = tgt_idx_reg;
        out_valid_next = out_valid_reg;
        out_hit_next   = out_hit_reg;
        out_evv_next   = out_evv_reg;
        out_evk_next   = out_evk_reg;

        ram_re    = 1'b0;
        ram_raddr = cnt_reg[IDX_W-1:0];
        ram_we    = 1'b0;
        ram_waddr = chk_idx_reg;
        ram_wdata = {rd_key, age_inc};

        if (cfg_we)
        begin
            cap_next = cfg_wdata;
        end

        // Result taken downstream
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    key_next   = in_ch.access_key;
                    cnt_next   = '0;
                    chk_next   = 1'b0;
                    found_next = 1'b0;
                    free_next  = 1'b0;
                    old_next   = 1'b0;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                chk_next = 1'b0;
                if (cnt_reg != CNT_W'(ENTRIES))
                begin
                    ram_re       = 1'b1;
                    chk_next     = 1'b1;
                    chk_idx_next = cnt_reg[IDX_W-1:0];
                    cnt_next     = cnt_reg + CNT_W'(1);
                end
                if (chk_reg)
                begin
                    if (ent_valid && res.key_eq && !found_reg)
                    begin
                        found_next     = 1'b1;
                        found_idx_next = chk_idx_reg;
                        found_age_next = rd_age;
                    end
                    if (!ent_valid && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = chk_idx_reg;
                    end
                    if (ent_valid && (!old_reg || res.age_gt))
                    begin
                        old_next     = 1'b1;
                        old_idx_next = chk_idx_reg;
                        old_age_next = rd_age;
                        old_key_next = rd_key;
                    end
                end
                if (sweep_end)
                begin
                    if (found_reg)
                    begin
                        kind_next    = KIND_HIT;
                        tgt_idx_next = found_idx_reg;
                    end
                    else if (CMP_W'(occ_reg) < eff_cap)
                    begin
                        kind_next    = KIND_INSERT;
                        tgt_idx_next = free_idx_reg;
                    end
                    else
                    begin
                        kind_next    = KIND_EVICT;
                        tgt_idx_next = old_idx_reg;
                    end
                    cnt_next   = '0;
                    state_next = ST_UPDATE;
                end
            end

            ST_UPDATE:
            begin
                chk_next = 1'b0;
                if (cnt_reg != CNT_W'(ENTRIES))
                begin
                    ram_re       = 1'b1;
                    chk_next     = 1'b1;
                    chk_idx_next = cnt_reg[IDX_W-1:0];
                    cnt_next     = cnt_reg + CNT_W'(1);
                end
                if (chk_reg)
                begin
                    if (chk_idx_reg == tgt_idx_reg)
                    begin
                        // accessed key becomes the most recent
                        ram_we    = 1'b1;
                        ram_wdata = {key_reg, AGE_W'(0)};
                    end
                    else if (ent_valid && ((kind_reg != KIND_HIT) || res.age_lt))
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = {rd_key, age_inc};
                    end
                end
                if (sweep_end)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = (kind_reg == KIND_HIT);
                    out_evv_next   = (kind_reg == KIND_EVICT);
                    out_evk_next   = (kind_reg == KIND_EVICT) ? old_key_reg : '0;
                    if (kind_reg == KIND_INSERT)
                    begin
                        valid_next[tgt_idx_reg] = 1'b1;
                        occ_next                = occ_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= KIND_HIT;
            cnt_reg       <= '0;
            chk_reg       <= 1'b0;
            chk_idx_reg   <= '0;
            key_reg       <= '0;
            valid_reg     <= '0;
            occ_reg       <= '0;
            cap_reg       <= CAP_RESET;
            found_reg     <= 1'b0;
            found_idx_reg <= '0;
            found_age_reg <= '0;
            free_reg      <= 1'b0;
            free_idx_reg  <= '0;
            old_reg       <= 1'b0;
            old_idx_reg   <= '0;
            old_age_reg   <= '0;
            old_key_reg   <= '0;
            tgt_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_hit_reg   <= 1'b0;
            out_evv_reg   <= 1'b0;
            out_evk_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            cnt_reg       <= cnt_next;
            chk_reg       <= chk_next;
            chk_idx_reg   <= chk_idx_next;
            key_reg       <= key_next;
            valid_reg     <= valid_next;
            occ_reg       <= occ_next;
            cap_reg       <= cap_next;
            found_reg     <= found_next;
            found_idx_reg <= found_idx_next;
            found_age_reg <= found_age_next;
            free_reg      <= free_next;
            free_idx_reg  <= free_idx_next;
            old_reg       <= old_next;
            old_idx_reg   <= old_idx_next;
            old_age_reg   <= old_age_next;
            old_key_reg   <= old_key_next;
            tgt_idx_reg   <= tgt_idx_next;
            out_valid_reg <= out_valid_next;
            out_hit_reg   <= out_hit_next;
            out_evv_reg   <= out_evv_next;
            out_evk_reg   <= out_evk_next;
        end
    end

endmodule

FILE: rtl/lkc_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lkc_checker
// Port-level checks on the LRU key cache policy, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lkc_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic                      hit,
    input logic                      evict_valid,
    input logic [lkc_pkg::KEY_W-1:0] evicted_key
);

    import lkc_pkg::*;

    logic in_acc;
    assign in_acc = in_valid && in_ready;

    // stalled result stays offered
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

    // one access in flight: ready drops after acceptance
    `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_acc, !in_ready, "second access taken while busy")

    // a result needs the search sweep first
    `ASSERT_NEXT(a_no_instant_result, clk, rst_n, in_acc, !$rose(out_valid), "result too early after access")

    // hit and eviction exclusive, evicted key zero when none
    `ASSERT_SAME(a_evict_fields, clk, rst_n, out_valid, !(hit && evict_valid) && (evict_valid || evicted_key == '0), "inconsistent eviction fields")

endmodule

bind lru_key_cache_policy lkc_checker u_lkc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .hit         (out_ch.hit),
    .evict_valid (out_ch.evict_valid),
    .evicted_key (out_ch.evicted_key)
);
